// ===== rtl/core/jfhf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jfhf_pkg;

  // Parser phase, one-hot
  typedef enum logic [14:0] {
    PH_SIG0  = 15'b000000000000001,
    PH_SIG1  = 15'b000000000000010,
    PH_MARK  = 15'b000000000000100,
    PH_TYPE  = 15'b000000000001000,
    PH_LENH  = 15'b000000000010000,
    PH_LENL  = 15'b000000000100000,
    PH_SKIP  = 15'b000000001000000,
    PH_SOFL1 = 15'b000000010000000,
    PH_SOFL2 = 15'b000000100000000,
    PH_PREC  = 15'b000001000000000,
    PH_HH    = 15'b000010000000000,
    PH_HL    = 15'b000100000000000,
    PH_WH    = 15'b001000000000000,
    PH_WL    = 15'b010000000000000,
    PH_COMP  = 15'b100000000000000
  } phase_t;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SIG   = 3'd1;
  localparam logic [2:0] ST_MARK  = 3'd2;
  localparam logic [2:0] ST_TYPE  = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  // Marker bytes
  localparam logic [7:0] MK_PREFIX   = 8'hFF;
  localparam logic [7:0] MK_SOI      = 8'hD8;
  localparam logic [7:0] MK_TYPE_MIN = 8'h01;
  localparam logic [7:0] MK_TYPE_MAX = 8'hFE;
  localparam logic [7:0] MK_SOF_LO   = 8'hC0;
  localparam logic [7:0] MK_SOF_HI   = 8'hCF;
  localparam logic [7:0] MK_DHT      = 8'hC4;
  localparam logic [7:0] MK_JPG      = 8'hC8;

  localparam logic [15:0] SEG_LEN_SELF = 16'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] bit_depth;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/jfhf_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Marker walker: holds the parse state and turns one byte into at most one result.
module jfhf_parse
  import jfhf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       file_start,
  input  wire logic       file_end,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [15:0] skip_count_r, skip_count_nxt, skip_cur, skip_dec;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [7:0]  sample_bits_r, sample_bits_nxt;
  logic [15:0] height_value_r, height_value_nxt;
  logic [7:0]  width_high_r, width_high_nxt;
  logic        finished_r, finished_nxt, fin_cur;
  logic        is_sof;
  logic [15:0] depth;

  // A file start wipes the state before the byte is handled as byte one.
  assign phase_cur = file_start ? PH_SIG0 : phase_r;
  assign skip_cur  = file_start ? 16'd0   : skip_count_r;
  assign fin_cur   = file_start ? 1'b0    : finished_r;
  assign skip_dec  = skip_cur - 16'd1;
  assign depth     = 16'(sample_bits_r) * 16'(data_byte);

  assign is_sof = (data_byte >= MK_SOF_LO) && (data_byte <= MK_SOF_HI) &&
                  (data_byte != MK_DHT) && (data_byte != MK_JPG);

  always_comb begin
    phase_nxt        = phase_cur;
    skip_count_nxt   = skip_cur;
    length_high_nxt  = file_start ? 8'd0  : length_high_r;
    sample_bits_nxt  = file_start ? 8'd0  : sample_bits_r;
    height_value_nxt = file_start ? 16'd0 : height_value_r;
    width_high_nxt   = file_start ? 8'd0  : width_high_r;
    res_valid        = 1'b0;
    res              = '0;
    if (!fin_cur) begin
      unique case (phase_cur)
        PH_SIG0: begin
          if (data_byte != MK_PREFIX) begin
            res_valid  = 1'b1;
            res.status = ST_SIG;
          end else begin
            phase_nxt = PH_SIG1;
          end
        end
        PH_SIG1: begin
          if (data_byte != MK_SOI) begin
            res_valid  = 1'b1;
            res.status = ST_SIG;
          end else begin
            phase_nxt = PH_MARK;
          end
        end
        PH_TYPE: begin
          if (data_byte < MK_TYPE_MIN || data_byte > MK_TYPE_MAX) begin
            res_valid  = 1'b1;
            res.status = ST_TYPE;
          end else if (is_sof) begin
            phase_nxt = PH_SOFL1;
          end else begin
            phase_nxt = PH_LENH;
          end
        end
        PH_LENH: begin
          length_high_nxt = data_byte;
          phase_nxt       = PH_LENL;
        end
        PH_LENL: begin
          // Length counts its own two bytes; lengths below two wrap round.
          skip_count_nxt = {length_high_r, data_byte} - SEG_LEN_SELF;
          phase_nxt      = (skip_count_nxt == 16'd0) ? PH_MARK : PH_SKIP;
        end
        PH_SKIP: begin
          skip_count_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_nxt = PH_MARK;
          end
        end
        PH_SOFL1: phase_nxt = PH_SOFL2;
        PH_SOFL2: phase_nxt = PH_PREC;
        PH_PREC: begin
          sample_bits_nxt = data_byte;
          phase_nxt       = PH_HH;
        end
        PH_HH: begin
          height_value_nxt = {data_byte, 8'd0};
          phase_nxt        = PH_HL;
        end
        PH_HL: begin
          height_value_nxt = {height_value_r[15:8], data_byte};
          phase_nxt        = PH_WH;
        end
        PH_WH: begin
          width_high_nxt = data_byte;
          phase_nxt      = PH_WL;
        end
        PH_WL: begin
          // The low width byte parks in the skip counter until the last byte.
          skip_count_nxt = {8'd0, data_byte};
          phase_nxt      = PH_COMP;
        end
        PH_COMP: begin
          res_valid        = 1'b1;
          res.status       = ST_OK;
          res.image_width  = {width_high_r, skip_count_r[7:0]};
          res.image_height = height_value_r;
          res.bit_depth    = depth;
        end
        default: begin
          if (data_byte != MK_PREFIX) begin
            res_valid  = 1'b1;
            res.status = ST_MARK;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      endcase
      if (!res_valid && file_end) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
      end
    end
    finished_nxt = fin_cur | res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SIG0;
      skip_count_r   <= '0;
      length_high_r  <= '0;
      sample_bits_r  <= '0;
      height_value_r <= '0;
      width_high_r   <= '0;
      finished_r     <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      skip_count_r   <= skip_count_nxt;
      length_high_r  <= length_high_nxt;
      sample_bits_r  <= sample_bits_nxt;
      height_value_r <= height_value_nxt;
      width_high_r   <= width_high_nxt;
      finished_r     <= finished_nxt;
    end
  end

  a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid |=> finished_r)
    else $error("result emitted but file not marked finished");

  a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && finished_r && !file_start |-> !res_valid)
    else $error("result emitted after file finished");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parser phase lost its one-hot code");

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_frame_header_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Word                                           Marks
// in_      in   tdata[7:0] data_byte                           tuser file_start, tlast file_end
// out_     out  tdata status, width, height, depth (56 bits)   none
//
// One byte is taken per cycle unless a stalled result holds the input. An accepted byte is
// held in the input register and parsed from there; its result, if any, then goes to the output register.
// The rate is set by the single output register: a byte is parsed only when that
// register is empty or being emptied, so a stalled result holds off one further byte.
// rst_n is synchronous and active low; after it the parser expects the FF of FF D8.
// Bytes after a result are dropped until a word carrying file_start arrives.
module jpeg_frame_header_finder
  import jfhf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] file_start
  input  wire logic        in_tlast,   // file_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // [2:0] status, [18:3] image_width,
                                       // [34:19] image_height, [50:35] bit_depth,
                                       // [55:51] zero
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       start_r;
  logic       last_r;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;

  // The held byte moves on when the result register can take whatever it makes.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = (advance && res_valid) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
      last_r  <= in_tlast;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  jfhf_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .data_byte  (byte_r),
    .file_start (start_r),
    .file_end   (last_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.bit_depth, out_r.image_height,
                       out_r.image_width, out_r.status};

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_TRUNC)
    else $error("status code out of range");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[50:3] == 48'd0)
    else $error("error result carries frame fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !advance)
    else $error("parser stepped while result register was stalled");

endmodule

`default_nettype wire
